// ===== hdl/config_line_key_value_parser_top_macros.svh =====
// Assertion macros used by the checker of the configuration line parser.
`ifndef CONFIG_LINE_KEY_VALUE_PARSER_TOP_MACROS_SVH
`define CONFIG_LINE_KEY_VALUE_PARSER_TOP_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define CFGKV_ASSERT_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("cfgkv assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define CFGKV_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("cfgkv assertion failed");

`endif

// ===== hdl/cfgkv_pkg.sv =====
package cfgkv_pkg;

  localparam logic [10:0] KEY_LIMIT   = 11'd64;
  localparam logic [10:0] VALUE_LIMIT = 11'd256;
  localparam logic [10:0] LINE_BYTES  = 11'd1024;
  localparam logic [10:0] ROOM_RESET  = 11'd1024;
  localparam logic [10:0] COUNT_MAX   = 11'h7FF;

  localparam logic [7:0] CH_NUL        = 8'h00;
  localparam logic [7:0] CH_TAB        = 8'h09;
  localparam logic [7:0] CH_LF         = 8'h0A;
  localparam logic [7:0] CH_CR         = 8'h0D;
  localparam logic [7:0] CH_SPACE      = 8'h20;
  localparam logic [7:0] CH_HASH       = 8'h23;
  localparam logic [7:0] CH_DASH       = 8'h2D;
  localparam logic [7:0] CH_DOT        = 8'h2E;
  localparam logic [7:0] CH_COLON      = 8'h3A;
  localparam logic [7:0] CH_EQUALS     = 8'h3D;
  localparam logic [7:0] CH_UNDERSCORE = 8'h5F;

  // Configuration register indexes.
  localparam logic CFG_KEY_ROOM   = 1'b0;
  localparam logic CFG_VALUE_ROOM = 1'b1;

  typedef enum logic [1:0] {
    KIND_BLANK = 2'd0,
    KIND_BAD   = 2'd1,
    KIND_ENTRY = 2'd2
  } kind_t;

  typedef enum logic [6:0] {
    PH_LEAD      = 7'b0000001,
    PH_KEY       = 7'b0000010,
    PH_AFTER_KEY = 7'b0000100,
    PH_AFTER_SEP = 7'b0001000,
    PH_VALUE     = 7'b0010000,
    PH_COMMENT   = 7'b0100000,
    PH_BAD       = 7'b1000000
  } phase_t;

  typedef struct packed {
    logic [7:0] char_byte;
    logic       has_byte;
    logic       line_last;
  } item_t;

  typedef struct packed {
    kind_t       line_kind;
    logic [9:0]  key_start;
    logic [7:0]  key_length;
    logic [10:0] value_start;
    logic [9:0]  value_length;
  } result_t;

  typedef struct packed {
    logic [10:0] key_room;
    logic [10:0] value_room;
  } rooms_t;

  function automatic logic is_space_tab(input logic [7:0] c);
    return (c == CH_SPACE) || (c == CH_TAB);
  endfunction

  function automatic logic is_term(input logic [7:0] c);
    return (c == CH_NUL) || (c == CH_LF) || (c == CH_CR);
  endfunction

  function automatic logic is_name_char(input logic [7:0] c);
    return (c >= 8'h61 && c <= 8'h7A) || (c >= 8'h41 && c <= 8'h5A) ||
           (c >= 8'h30 && c <= 8'h39) || (c == CH_DOT) ||
           (c == CH_UNDERSCORE) || (c == CH_DASH);
  endfunction

endpackage

// ===== hdl/cfgkv_in_reg.sv =====
module cfgkv_in_reg (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_stall,
  input  cfgkv_pkg::item_t in_item,
  input  logic            take,
  output logic            full,
  output cfgkv_pkg::item_t item
);
  import cfgkv_pkg::*;

  logic load;

  assign in_stall = full && !take;
  assign load     = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      full <= 1'b0;
    end else if (load) begin
      full <= 1'b1;
    end else if (take) begin
      full <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      item <= in_item;
    end
  end

endmodule

// ===== hdl/cfgkv_scan.sv =====
module cfgkv_scan (
  input  logic              clk,
  input  logic              rst,
  input  logic              fire,
  input  cfgkv_pkg::item_t  item,
  input  cfgkv_pkg::rooms_t rooms,
  output cfgkv_pkg::result_t result
);
  import cfgkv_pkg::*;

  logic [10:0] pos, pos_next;
  phase_t      phase, phase_next;
  logic [9:0]  key_begin, key_begin_next;
  logic [10:0] key_count, key_count_next;
  logic        inner_dot, inner_dot_next;
  logic        dot_end, dot_end_next;
  logic [10:0] value_begin, value_begin_next;
  logic [10:0] value_end, value_end_next;
  logic        ended, ended_next;

  logic [7:0]  c;
  logic [10:0] vstart;
  logic [10:0] vlen;
  logic        empty_value;
  logic        too_long;
  kind_t       kind;

  assign c = item.char_byte;

  // Effect of one byte on the line state.
  always_comb begin
    pos_next         = pos;
    phase_next       = phase;
    key_begin_next   = key_begin;
    key_count_next   = key_count;
    inner_dot_next   = inner_dot;
    dot_end_next     = dot_end;
    value_begin_next = value_begin;
    value_end_next   = value_end;
    ended_next       = ended;
    if (item.has_byte && !ended) begin
      if (is_term(c)) begin
        ended_next = 1'b1;
      end else if (pos >= LINE_BYTES) begin
        phase_next = PH_BAD;
      end else begin
        pos_next = pos + 11'd1;
        case (phase)
          PH_LEAD: begin
            if (c == CH_HASH) begin
              phase_next = PH_COMMENT;
            end else if (is_name_char(c)) begin
              phase_next     = PH_KEY;
              key_begin_next = pos[9:0];
              key_count_next = 11'd1;
              dot_end_next   = 1'b0;
            end else if (!is_space_tab(c)) begin
              phase_next = PH_BAD;
            end
          end
          PH_KEY: begin
            if (is_name_char(c)) begin
              if (dot_end) begin
                inner_dot_next = 1'b1;
              end
              dot_end_next = (c == CH_DOT);
              if (key_count != COUNT_MAX) begin
                key_count_next = key_count + 11'd1;
              end
            end else if (!inner_dot) begin
              phase_next = PH_BAD;
            end else if (is_space_tab(c)) begin
              phase_next = PH_AFTER_KEY;
            end else if (c == CH_COLON || c == CH_EQUALS) begin
              phase_next = PH_AFTER_SEP;
            end else begin
              phase_next = PH_BAD;
            end
          end
          PH_AFTER_KEY: begin
            if (c == CH_COLON || c == CH_EQUALS) begin
              phase_next = PH_AFTER_SEP;
            end else if (!is_space_tab(c)) begin
              phase_next       = PH_VALUE;
              value_begin_next = pos;
              value_end_next   = pos + 11'd1;
            end
          end
          PH_AFTER_SEP: begin
            if (!is_space_tab(c)) begin
              phase_next       = PH_VALUE;
              value_begin_next = pos;
              value_end_next   = pos + 11'd1;
            end
          end
          PH_VALUE: begin
            if (!is_space_tab(c)) begin
              value_end_next = pos + 11'd1;
            end
          end
          default: begin
          end
        endcase
      end
    end
  end

  // Line verdict, taken from the state after this byte.
  always_comb begin
    kind        = KIND_BAD;
    empty_value = 1'b0;
    case (phase_next)
      PH_LEAD, PH_COMMENT: begin
        kind = KIND_BLANK;
      end
      PH_KEY: begin
        if (inner_dot_next) begin
          kind        = KIND_ENTRY;
          empty_value = 1'b1;
        end
      end
      PH_AFTER_KEY, PH_AFTER_SEP: begin
        kind        = KIND_ENTRY;
        empty_value = 1'b1;
      end
      PH_VALUE: begin
        kind = KIND_ENTRY;
      end
      default: begin
        kind = KIND_BAD;
      end
    endcase
  end

  assign vstart = empty_value ? pos_next : value_begin_next;
  assign vlen   = empty_value ? 11'd0 : (value_end_next - value_begin_next);

  assign too_long = ({1'b0, key_count_next} + 12'd1 > {1'b0, rooms.key_room}) ||
                    (key_count_next >= KEY_LIMIT) ||
                    ({1'b0, vlen} + 12'd1 > {1'b0, rooms.value_room}) ||
                    (vlen >= VALUE_LIMIT);

  always_comb begin
    result = '0;
    if (kind == KIND_ENTRY) begin
      if (too_long) begin
        result.line_kind = KIND_BAD;
      end else begin
        result.line_kind    = KIND_ENTRY;
        result.key_start    = key_begin_next;
        result.key_length   = key_count_next[7:0];
        result.value_start  = vstart;
        result.value_length = vlen[9:0];
      end
    end else begin
      result.line_kind = kind;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || (fire && item.line_last)) begin
      pos         <= '0;
      phase       <= PH_LEAD;
      key_begin   <= '0;
      key_count   <= '0;
      inner_dot   <= 1'b0;
      dot_end     <= 1'b0;
      value_begin <= '0;
      value_end   <= '0;
      ended       <= 1'b0;
    end else if (fire) begin
      pos         <= pos_next;
      phase       <= phase_next;
      key_begin   <= key_begin_next;
      key_count   <= key_count_next;
      inner_dot   <= inner_dot_next;
      dot_end     <= dot_end_next;
      value_begin <= value_begin_next;
      value_end   <= value_end_next;
      ended       <= ended_next;
    end
  end

endmodule

// ===== hdl/cfgkv_out_reg.sv =====
module cfgkv_out_reg (
  input  logic                clk,
  input  logic                rst,
  input  logic                load,
  input  cfgkv_pkg::result_t  result_in,
  output logic                ready,
  output logic                out_valid,
  input  logic                out_stall,
  output cfgkv_pkg::result_t  result
);
  import cfgkv_pkg::*;

  assign ready = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (ready) begin
      out_valid <= load;
    end
  end

  always_ff @(posedge clk) begin
    if (ready && load) begin
      result <= result_in;
    end
  end

endmodule

// ===== hdl/config_line_key_value_parser_top.sv =====
// Configuration line parser: scans one text line a byte at a time and gives one
// verdict per line (blank or comment, bad, or key/value entry with positions).
// Input channel: in_valid/in_stall with char_byte, has_byte and line_last; a
// transaction completes at a clock edge with in_valid high and in_stall low.
// Output channel: out_valid/out_stall carrying line_kind and the key and value
// positions; one transaction is produced for each input transaction with
// line_last set, none for the others.
// The cfg_we/cfg_index/cfg_data port writes key_room (index 0) or value_room
// (index 1); write only while no line is in flight.
// The verdict for a closing input transaction goes from the input register
// through one pass of the scanner into the result register, and is offered on
// the output from there. Throughput is one item per cycle, except while a
// closing item waits for an untaken verdict in the result register.
// Reset (rst, synchronous) empties both registers, returns the line state to
// the leading-blank phase and sets both room registers to 1024.
// A stalled receiver holds the result steady; the next line's bytes keep
// flowing until a second closing item needs the result register.
module config_line_key_value_parser_top (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  char_byte,
  input  logic        has_byte,
  input  logic        line_last,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  line_kind,
  output logic [9:0]  key_start,
  output logic [7:0]  key_length,
  output logic [10:0] value_start,
  output logic [9:0]  value_length,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [10:0] cfg_data
);
  import cfgkv_pkg::*;

  item_t   in_item;
  item_t   item;
  logic    full;
  logic    take;
  logic    out_ready;
  rooms_t  rooms;
  result_t scan_result;
  result_t result;

  // Room registers; a write applies to every byte scanned after it.
  always_ff @(posedge clk) begin
    if (rst) begin
      rooms.key_room   <= ROOM_RESET;
      rooms.value_room <= ROOM_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_KEY_ROOM:   rooms.key_room   <= cfg_data;
        CFG_VALUE_ROOM: rooms.value_room <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  assign in_item.char_byte = char_byte;
  assign in_item.has_byte  = has_byte;
  assign in_item.line_last = line_last;

  // A held item goes through the scanner unless it closes a line and the
  // result register is still occupied by an untaken verdict.
  assign take = full && (!item.line_last || out_ready);

  cfgkv_in_reg u_in_reg (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_item  (in_item),
    .take     (take),
    .full     (full),
    .item     (item)
  );

  cfgkv_scan u_scan (
    .clk    (clk),
    .rst    (rst),
    .fire   (take),
    .item   (item),
    .rooms  (rooms),
    .result (scan_result)
  );

  cfgkv_out_reg u_out_reg (
    .clk       (clk),
    .rst       (rst),
    .load      (take && item.line_last),
    .result_in (scan_result),
    .ready     (out_ready),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .result    (result)
  );

  assign line_kind    = result.line_kind;
  assign key_start    = result.key_start;
  assign key_length   = result.key_length;
  assign value_start  = result.value_start;
  assign value_length = result.value_length;

endmodule

// ===== hdl/cfgkv_checker.sv =====
`include "config_line_key_value_parser_top_macros.svh"

module cfgkv_checker (
  input logic        clk,
  input logic        rst,
  input logic        out_valid,
  input logic        out_stall,
  input logic [1:0]  line_kind,
  input logic [9:0]  key_start,
  input logic [7:0]  key_length,
  input logic [10:0] value_start,
  input logic [9:0]  value_length
);
  import cfgkv_pkg::*;

  // A stalled result stays offered with its kind and value fields unchanged.
  `CFGKV_ASSERT_NEXT(a_out_hold, out_valid && out_stall,
    out_valid && $stable(line_kind) && $stable(value_start) && $stable(value_length))

  // Lines that are not entries report all positions as zero.
  `CFGKV_ASSERT_SAME(a_nonentry_zero, out_valid && line_kind != KIND_ENTRY,
    key_start == 10'd0 && key_length == 8'd0 && value_start == 11'd0 &&
    value_length == 10'd0)

  // An entry key holds an inner dot, so at least three bytes, and fits the limit.
  `CFGKV_ASSERT_SAME(a_entry_key, out_valid && line_kind == KIND_ENTRY,
    key_length >= 8'd3 && 11'(key_length) < KEY_LIMIT)

  // An entry value fits the limit and lies inside a line of legal length.
  `CFGKV_ASSERT_SAME(a_entry_value, out_valid && line_kind == KIND_ENTRY,
    11'(value_length) < VALUE_LIMIT && value_start <= LINE_BYTES)

endmodule

bind config_line_key_value_parser_top cfgkv_checker u_checker (.*);
